>>> rtl/core/platform_interrupt_controller_unit_defines.svh
// Assertion macros used by the interrupt controller core.
`ifndef PLATFORM_INTERRUPT_CONTROLLER_UNIT_DEFINES_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define PLIC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define PLIC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/plic_pkg.sv
// Types and constants shared by the interrupt controller modules.
package plic_pkg;

   typedef struct packed {
      logic [1:0]  op;
      logic [23:0] word_addr;
      logic [31:0] wdata;
      logic [4:0]  source_id;
   } plic_req_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic        access_fault;
      logic [3:0]  irq_lines;
   } plic_rsp_type;

   typedef struct packed {
      logic [5:0] sources_in_use;
      logic [2:0] targets_in_use;
   } plic_cfg_type;

   typedef struct packed {
      logic start;
      logic res_take;
   } plic_ctl_in_type;

   typedef struct packed {
      logic idle;
      logic res_valid;
   } plic_ctl_out_type;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_RAISE = 2'd2;

   localparam logic [1:0] PH_WAITING = 2'd0;
   localparam logic [1:0] PH_PENDING = 2'd1;
   localparam logic [1:0] PH_CLAIMED = 2'd2;

   localparam logic [23:0] PEND_BASE = 24'h000400;
   localparam logic [23:0] ENAB_BASE = 24'h000800;
   localparam logic [23:0] CTX_BASE  = 24'h080000;

   localparam logic [9:0] CTX_THRESHOLD = 10'd0;
   localparam logic [9:0] CTX_CLAIM     = 10'd1;

   localparam logic CSR_SOURCES = 1'b0;
   localparam logic CSR_TARGETS = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_ACCESS, ST_SCAN, ST_CLAIM_WB,
      ST_IRQ_START, ST_IRQ_TGT, ST_IRQ_THR, ST_DONE
   } plic_state_type;

   typedef enum logic [2:0] {
      K_NONE, K_PRIO, K_PEND, K_ENAB, K_THR, K_CLAIM, K_COMPLETE, K_RAISE
   } plic_kind_type;

   typedef enum logic [1:0] {
      SM_PEND, SM_CLAIM, SM_IRQ
   } plic_scan_type;

endpackage

>>> rtl/core/plic_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module plic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

>>> rtl/core/plic_core.sv
// Sequencer: decodes a word, updates the source and target memories, scans for irq.
module plic_core import plic_pkg::*; #(
   parameter int NUM_SOURCES   = 32,
   parameter int NUM_TARGETS   = 4,
   parameter int PRIORITY_BITS = 3,
   parameter int TALLY_BITS    = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  plic_ctl_in_type  ctl_in,
   input  plic_req_type     req,
   input  plic_cfg_type     cfg,
   output plic_ctl_out_type ctl_out,
   output plic_rsp_type     rsp
);

`include "platform_interrupt_controller_unit_defines.svh"

   localparam int SW    = $clog2(NUM_SOURCES);
   localparam int CW    = SW + 1;
   localparam int EW    = (NUM_SOURCES + 31) / 32;
   localparam int ROWS  = NUM_TARGETS * EW;
   localparam int RB    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PB    = PRIORITY_BITS;
   localparam int TLB   = TALLY_BITS;
   localparam int SEW   = PB + TLB + 2;
   localparam int TEW   = PB + 32;
   localparam int CLR_N = (NUM_SOURCES > ROWS) ? NUM_SOURCES : ROWS;
   localparam int CLRB  = $clog2(CLR_N);
   localparam logic [TLB-1:0] TALLY_MAX = {TLB{1'b1}};

   plic_state_type   state_ff, state_in;
   plic_kind_type    kind_ff, kind_in;
   plic_scan_type    mode_ff, mode_in;
   plic_req_type     req_ff, req_in;
   logic             fault_ff, fault_in;
   logic [31:0]      rdata_ff, rdata_in;
   logic [3:0]       lines_ff, lines_in;
   logic [SW-1:0]    src_ff, src_in;
   logic [RB-1:0]    row_ff, row_in;
   logic [CW-1:0]    s_ff, s_in;
   logic [CW-1:0]    end_ff, end_in;
   logic             vld_ff, vld_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    best_ff, best_in;
   logic [PB-1:0]    bp_ff, bp_in;
   logic [RB-1:0]    base_ff, base_in;
   logic [2:0]       irq_t_ff, irq_t_in;
   logic [CLRB-1:0]  clr_ff, clr_in;

   logic             src_we, src_re, tgt_we, tgt_re;
   logic [SW-1:0]    src_wa, src_ra;
   logic [RB-1:0]    tgt_wa, tgt_ra;
   logic [SEW-1:0]   src_wd, src_rd;
   logic [TEW-1:0]   tgt_wd, tgt_rd;

   logic [CW-1:0]    ls_eff;
   logic [2:0]       lt_eff, irq_cnt;
   plic_kind_type    dec_kind;
   logic             dec_fault;
   logic [SW-1:0]    dec_src;
   logic [RB-1:0]    dec_row;
   logic [CW-1:0]    dec_pstart, dec_pend;
   logic [23:0]      ctx_off, en_off;
   logic [9:0]       pend_w;
   logic [31:0]      pend_top;
   logic             wr;
   logic             scan_done;

   logic [PB-1:0]    s_prio;
   logic [TLB-1:0]   s_tally;
   logic [1:0]       s_phase;
   logic [PB-1:0]    t_thr;
   logic [31:0]      t_en;

   function automatic logic word_ok(input logic [9:0] w, input logic [CW-1:0] lsv);
      return (32'(w) < 32'(EW)) && (32'({w, 5'b0}) < 32'(lsv));
   endfunction

   plic_ram #(.WIDTH(SEW), .DEPTH(NUM_SOURCES)) u_src_ram (
      .clock(clock), .we(src_we), .waddr(src_wa), .wdata(src_wd),
      .re(src_re), .raddr(src_ra), .rdata(src_rd)
   );

   plic_ram #(.WIDTH(TEW), .DEPTH(ROWS)) u_tgt_ram (
      .clock(clock), .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd),
      .re(tgt_re), .raddr(tgt_ra), .rdata(tgt_rd)
   );

   assign s_prio    = src_rd[SEW-1 -: PB];
   assign s_tally   = src_rd[2 +: TLB];
   assign s_phase   = src_rd[1:0];
   assign t_thr     = tgt_rd[TEW-1 -: PB];
   assign t_en      = tgt_rd[31:0];
   assign wr        = (req_ff.op == OP_WRITE);
   assign scan_done = (s_ff >= end_ff) && !vld_ff;

   // live counts clamp the registers to what was built
   always_comb begin
      ls_eff  = (32'(cfg.sources_in_use) > 32'(NUM_SOURCES)) ? CW'(NUM_SOURCES)
                                                             : CW'(cfg.sources_in_use);
      lt_eff  = (32'(cfg.targets_in_use) > 32'(NUM_TARGETS)) ? 3'(NUM_TARGETS)
                                                             : cfg.targets_in_use;
      irq_cnt = (lt_eff > 3'd4) ? 3'd4 : lt_eff;
   end

   // address decode of the latched word
   always_comb begin
      ctx_off    = req_ff.word_addr - CTX_BASE;
      en_off     = req_ff.word_addr - ENAB_BASE;
      pend_w     = 10'(req_ff.word_addr - PEND_BASE);
      pend_top   = 32'({pend_w, 5'b0}) + 32'd32;
      dec_kind   = K_NONE;
      dec_fault  = 1'b0;
      dec_src    = '0;
      dec_row    = '0;
      dec_pstart = CW'({pend_w, 5'b0});
      dec_pend   = (pend_top > 32'(NUM_SOURCES)) ? CW'(NUM_SOURCES) : CW'(pend_top);
      if (req_ff.op == OP_RAISE) begin
         if (req_ff.source_id == 5'd0 || 32'(req_ff.source_id) >= 32'(ls_eff)) begin
            dec_fault = 1'b1;
         end else begin
            dec_kind = K_RAISE;
            dec_src  = SW'(req_ff.source_id);
         end
      end else if (req_ff.op == OP_READ || req_ff.op == OP_WRITE) begin
         if (req_ff.word_addr >= CTX_BASE) begin
            if (32'(ctx_off[23:10]) >= 32'(lt_eff)) begin
               dec_fault = 1'b1;
            end else begin
               dec_row = RB'(ctx_off[23:10]) * RB'(EW);
               if (ctx_off[9:0] == CTX_THRESHOLD) begin
                  dec_kind = K_THR;
               end else if (ctx_off[9:0] == CTX_CLAIM) begin
                  if (!wr) begin
                     dec_kind = K_CLAIM;
                  end else if (req_ff.wdata != 32'd0 &&
                               req_ff.wdata < 32'(ls_eff)) begin
                     dec_kind = K_COMPLETE;
                     dec_src  = SW'(req_ff.wdata);
                  end
               end
            end
         end else if (req_ff.word_addr >= ENAB_BASE) begin
            if (32'(en_off[23:5]) >= 32'(lt_eff) ||
                !word_ok({5'b0, en_off[4:0]}, ls_eff)) begin
               dec_fault = 1'b1;
            end else begin
               dec_kind = K_ENAB;
               dec_row  = RB'(en_off[23:5]) * RB'(EW) + RB'(en_off[4:0]);
            end
         end else if (req_ff.word_addr >= PEND_BASE) begin
            if (!word_ok(pend_w, ls_eff)) begin
               dec_fault = 1'b1;
            end else if (!wr) begin
               dec_kind = K_PEND;
            end
         end else begin
            if (32'(req_ff.word_addr[9:0]) >= 32'(ls_eff)) begin
               dec_fault = 1'b1;
            end else begin
               dec_kind = K_PRIO;
               dec_src  = SW'(req_ff.word_addr[9:0]);
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLRB'(CLR_N - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (ctl_in.start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (dec_kind inside {K_PRIO, K_RAISE, K_COMPLETE, K_ENAB, K_THR}) begin
               state_in = ST_ACCESS;
            end else if (dec_kind inside {K_CLAIM, K_PEND}) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IRQ_START;
            end
         end
         ST_ACCESS: state_in = ST_IRQ_START;
         ST_SCAN: begin
            if (scan_done) begin
               case (mode_ff)
                  SM_CLAIM: state_in = (best_ff != '0) ? ST_CLAIM_WB : ST_IRQ_START;
                  SM_IRQ:   state_in = ST_IRQ_TGT;
                  default:  state_in = ST_IRQ_START;
               endcase
            end
         end
         ST_CLAIM_WB:  state_in = ST_IRQ_START;
         ST_IRQ_START: state_in = ST_IRQ_TGT;
         ST_IRQ_TGT:   state_in = (irq_t_ff < irq_cnt) ? ST_IRQ_THR : ST_DONE;
         ST_IRQ_THR:   state_in = ST_SCAN;
         ST_DONE: begin
            if (ctl_in.res_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      kind_in  = kind_ff;
      mode_in  = mode_ff;
      req_in   = req_ff;
      fault_in = fault_ff;
      rdata_in = rdata_ff;
      lines_in = lines_ff;
      src_in   = src_ff;
      row_in   = row_ff;
      s_in     = s_ff;
      end_in   = end_ff;
      vld_in   = 1'b0;
      idx_in   = idx_ff;
      best_in  = best_ff;
      bp_in    = bp_ff;
      base_in  = base_ff;
      irq_t_in = irq_t_ff;
      clr_in   = clr_ff;
      src_we   = 1'b0;
      src_wa   = src_ff;
      src_wd   = src_rd;
      src_re   = 1'b0;
      src_ra   = src_ff;
      tgt_we   = 1'b0;
      tgt_wa   = row_ff;
      tgt_wd   = tgt_rd;
      tgt_re   = 1'b0;
      tgt_ra   = row_ff;
      ctl_out.idle      = 1'b0;
      ctl_out.res_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            src_we = (32'(clr_ff) < 32'(NUM_SOURCES));
            src_wa = SW'(clr_ff);
            src_wd = {PB'(0), TLB'(0), PH_WAITING};
            tgt_we = (32'(clr_ff) < 32'(ROWS));
            tgt_wa = RB'(clr_ff);
            tgt_wd = '0;
            clr_in = clr_ff + CLRB'(1);
         end
         ST_IDLE: begin
            ctl_out.idle = 1'b1;
            if (ctl_in.start) req_in = req;
         end
         ST_DECODE: begin
            kind_in  = dec_kind;
            fault_in = dec_fault;
            rdata_in = '0;
            src_in   = dec_src;
            row_in   = dec_row;
            src_re   = (dec_kind inside {K_PRIO, K_RAISE, K_COMPLETE});
            src_ra   = dec_src;
            tgt_re   = (dec_kind inside {K_ENAB, K_THR});
            tgt_ra   = dec_row;
            best_in  = '0;
            bp_in    = '0;
            base_in  = dec_row;
            if (dec_kind == K_CLAIM) begin
               mode_in = SM_CLAIM;
               s_in    = CW'(1);
               end_in  = ls_eff;
            end else begin
               mode_in = SM_PEND;
               s_in    = dec_pstart;
               end_in  = dec_pend;
            end
         end
         ST_ACCESS: begin
            case (kind_ff)
               K_PRIO: begin
                  if (wr) begin
                     src_we = 1'b1;
                     src_wd = {req_ff.wdata[PB-1:0], s_tally, s_phase};
                  end else begin
                     rdata_in = 32'(s_prio);
                  end
               end
               K_RAISE: begin
                  src_we = 1'b1;
                  src_wd = {s_prio, (s_tally == TALLY_MAX) ? s_tally : s_tally + TLB'(1),
                            (s_phase == PH_WAITING) ? PH_PENDING : s_phase};
               end
               K_COMPLETE: begin
                  src_we = (s_phase == PH_CLAIMED);
                  src_wd = {s_prio, s_tally,
                            (s_tally != '0) ? PH_PENDING : PH_WAITING};
               end
               K_ENAB: begin
                  if (wr) begin
                     tgt_we = 1'b1;
                     tgt_wd = {t_thr, req_ff.wdata};
                  end else begin
                     rdata_in = t_en;
                  end
               end
               K_THR: begin
                  if (wr) begin
                     tgt_we = 1'b1;
                     tgt_wd = {req_ff.wdata[PB-1:0], t_en};
                  end else begin
                     rdata_in = 32'(t_thr);
                  end
               end
               default: ;
            endcase
         end
         ST_SCAN: begin
            // evaluate the entry read last cycle
            if (vld_ff) begin
               if (mode_ff == SM_PEND) begin
                  if (s_tally != '0) rdata_in[5'(idx_ff)] = 1'b1;
               end else if (s_phase == PH_PENDING && t_en[5'(idx_ff)] &&
                            s_prio > bp_ff) begin
                  bp_in   = s_prio;
                  best_in = idx_ff;
               end
            end
            // issue the next entry
            if (s_ff < end_ff) begin
               src_re = 1'b1;
               src_ra = SW'(s_ff);
               tgt_re = 1'b1;
               tgt_ra = base_ff + RB'(s_ff >> 5);
               vld_in = 1'b1;
               idx_in = s_ff;
               s_in   = s_ff + CW'(1);
            end
            if (scan_done) begin
               if (mode_ff == SM_CLAIM) begin
                  src_re = (best_ff != '0);
                  src_ra = SW'(best_ff);
               end else if (mode_ff == SM_IRQ) begin
                  lines_in[irq_t_ff[1:0]] = (best_ff != '0);
                  irq_t_in = irq_t_ff + 3'd1;
               end
            end
         end
         ST_CLAIM_WB: begin
            src_we   = 1'b1;
            src_wa   = SW'(best_ff);
            src_wd   = {s_prio, (s_tally != '0) ? s_tally - TLB'(1) : s_tally, PH_CLAIMED};
            rdata_in = 32'(best_ff);
         end
         ST_IRQ_START: begin
            irq_t_in = 3'd0;
            lines_in = 4'd0;
         end
         ST_IRQ_TGT: begin
            tgt_re = (irq_t_ff < irq_cnt);
            tgt_ra = RB'(irq_t_ff) * RB'(EW);
         end
         ST_IRQ_THR: begin
            mode_in = SM_IRQ;
            bp_in   = t_thr;
            best_in = '0;
            s_in    = CW'(1);
            end_in  = ls_eff;
            base_in = RB'(irq_t_ff) * RB'(EW);
         end
         ST_DONE: begin
            ctl_out.res_valid = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp.rdata        = rdata_ff;
   assign rsp.access_fault = fault_ff;
   assign rsp.irq_lines    = lines_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      mode_ff  <= mode_in;
      req_ff   <= req_in;
      fault_ff <= fault_in;
      rdata_ff <= rdata_in;
      lines_ff <= lines_in;
      src_ff   <= src_in;
      row_ff   <= row_in;
      s_ff     <= s_in;
      end_ff   <= end_in;
      idx_ff   <= idx_in;
      best_ff  <= best_in;
      bp_ff    <= bp_in;
      base_ff  <= base_in;
      irq_t_ff <= irq_t_in;
   end

   `PLIC_ASSERT_NEXT(a_result_holds, ctl_out.res_valid && !ctl_in.res_take, ctl_out.res_valid && $stable(rsp), "result changed while waiting")
   `PLIC_ASSERT_NOW(a_src_port_clash, src_we && src_re, src_wa != src_ra, "source memory read and write collide")
   `PLIC_ASSERT_NOW(a_claim_has_source, state_ff == ST_CLAIM_WB, best_ff != '0, "claim write-back without a source")
   `PLIC_ASSERT_NOW(a_start_when_idle, ctl_in.start, state_ff == ST_IDLE, "item started while busy")

endmodule

>>> rtl/core/platform_interrupt_controller_unit.sv
// Interrupt controller top level: word handshakes, configuration registers, core.
//
// After reset the block clears its source and target memories, one entry per cycle,
// max(NUM_SOURCES, NUM_TARGETS * ceil(NUM_SOURCES / 32)) entries in all, and takes no word
// meanwhile. It then serves one word at a time: it decodes the word, accesses the
// addressed entry, then, for each of the first four live targets, scans the live sources
// to rebuild the irq lines; a claim read replaces the access with one more scan of the
// live sources and a write-back, a pending read with a scan of up to 32 entries.
// The scans are paced by the single read port of each memory, read once per source.
// A finished result sits in an output register, so the next word is taken while it waits.
module platform_interrupt_controller_unit import plic_pkg::*; #(
   parameter int NUM_SOURCES   = 32,
   parameter int NUM_TARGETS   = 4,
   parameter int PRIORITY_BITS = 3,
   parameter int TALLY_BITS    = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  plic_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output plic_rsp_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic [5:0]       sources_ff, sources_in;
   logic [2:0]       targets_ff, targets_in;
   logic             rsp_valid_ff, rsp_valid_in;
   plic_rsp_type     rsp_ff, rsp_in;
   plic_ctl_in_type  ctl_in;
   plic_ctl_out_type ctl_out;
   plic_cfg_type     cfg;
   plic_rsp_type     core_rsp;
   logic             cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == CSR_TARGETS) ? {29'd0, targets_ff} : {26'd0, sources_ff};

   assign cfg.sources_in_use = sources_ff;
   assign cfg.targets_in_use = targets_ff;

   assign req_ready       = ctl_out.idle;
   assign ctl_in.start    = req_valid && ctl_out.idle;
   assign ctl_in.res_take = ctl_out.res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      sources_in   = sources_ff;
      targets_in   = targets_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cfg_write) begin
         if (paddr[2] == CSR_SOURCES) sources_in = pwdata[5:0];
         else                         targets_in = pwdata[2:0];
      end
      // drop the word once taken, load the next finished one
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (ctl_in.res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sources_ff   <= 6'd32;
         targets_ff   <= 3'd4;
         rsp_valid_ff <= 1'b0;
      end else begin
         sources_ff   <= sources_in;
         targets_ff   <= targets_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   plic_core #(
      .NUM_SOURCES(NUM_SOURCES), .NUM_TARGETS(NUM_TARGETS),
      .PRIORITY_BITS(PRIORITY_BITS), .TALLY_BITS(TALLY_BITS)
   ) u_core (
      .clock(clock), .reset(reset), .ctl_in(ctl_in), .req(req_data), .cfg(cfg),
      .ctl_out(ctl_out), .rsp(core_rsp)
   );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the platform interrupt controller unit.
`timescale 1ns / 1ps

module tb_top;
   import plic_pkg::*;

   localparam logic [1:0] OP_NONE   = 2'd3;
   localparam int         HOLD_LONG = 2000;
   localparam int         SETTLE    = 400;

   // Tracks controller state and the queue of expected response words.
   class irq_ledger;
      int                 live_src;
      int                 live_tgt;
      logic [2:0]         prio [32];
      logic [7:0]         tally [32];
      logic [1:0]         phase [32];
      logic [31:0]        enab [4];
      logic [2:0]         thresh [4];
      plic_rsp_type       expected_rsps [$];
      int                 errors;

      function new();
         live_src = 32;
         live_tgt = 4;
         errors = 0;
         for (int i = 0; i < 32; i++) begin
            prio[i] = '0;
            tally[i] = '0;
            phase[i] = PH_WAITING;
         end
         for (int i = 0; i < 4; i++) begin
            enab[i] = '0;
            thresh[i] = '0;
         end
      endfunction

      function void set_cfg(logic csr, logic [31:0] value);
         if (csr == CSR_SOURCES) live_src = (value[5:0] < 32) ? value[5:0] : 32;
         else live_tgt = (value[2:0] < 4) ? value[2:0] : 4;
      endfunction

      function int best_src(int t, int floor);
         int b;
         int bp;
         b = 0;
         bp = floor;
         for (int s = 1; s < live_src; s++) begin
            if (phase[s] == PH_PENDING && enab[t][s] && prio[s] > bp) begin
               bp = prio[s];
               b = s;
            end
         end
         return b;
      endfunction

      function bit bus(bit wr, int unsigned a, logic [31:0] d, output logic [31:0] rd);
         int unsigned c, t, r;
         int          s;
         rd = '0;
         if (a >= CTX_BASE) begin
            c = a - CTX_BASE;
            t = c / 1024;
            r = c % 1024;
            if (t >= live_tgt) return 1;
            if (r == CTX_THRESHOLD) begin
               if (wr) thresh[t] = d[2:0];
               else rd = 32'(thresh[t]);
            end else if (r == CTX_CLAIM) begin
               if (wr) begin
                  if (d != 0 && d < live_src && phase[d[4:0]] == PH_CLAIMED)
                     phase[d[4:0]] = (tally[d[4:0]] != 0) ? PH_PENDING : PH_WAITING;
               end else begin
                  s = best_src(t, 0);
                  if (s != 0) begin
                     phase[s] = PH_CLAIMED;
                     if (tally[s] != 0) tally[s]--;
                  end
                  rd = s;
               end
            end
            return 0;
         end
         if (a >= ENAB_BASE) begin
            c = a - ENAB_BASE;
            t = c / 32;
            r = c % 32;
            if (t >= live_tgt || r != 0 || live_src == 0) return 1;
            if (wr) enab[t] = d;
            else rd = enab[t];
            return 0;
         end
         if (a >= PEND_BASE) begin
            if (a != PEND_BASE || live_src == 0) return 1;
            if (!wr)
               for (int i = 0; i < 32; i++) rd[i] = (tally[i] != 0);
            return 0;
         end
         if (a >= live_src) return 1;
         if (wr) prio[a] = d[2:0];
         else rd = 32'(prio[a]);
         return 0;
      endfunction

      function void note_word(plic_req_type q);
         plic_rsp_type e;
         logic [31:0]  rd;
         e = '0;
         rd = '0;
         if (q.op == OP_READ || q.op == OP_WRITE) begin
            e.access_fault = bus(q.op == OP_WRITE, 32'(q.word_addr), q.wdata, rd);
            e.rdata = rd;
         end else if (q.op == OP_RAISE) begin
            if (q.source_id == 0 || q.source_id >= live_src) begin
               e.access_fault = 1'b1;
            end else begin
               if (tally[q.source_id] != 8'hFF) tally[q.source_id]++;
               if (phase[q.source_id] == PH_WAITING) phase[q.source_id] = PH_PENDING;
            end
         end
         for (int t = 0; t < live_tgt && t < 4; t++)
            e.irq_lines[t] = (best_src(t, thresh[t]) != 0);
         expected_rsps.push_back(e);
      endfunction

      function void check_word(plic_rsp_type got);
         plic_rsp_type e;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         e = expected_rsps.pop_front();
         if (got.rdata !== e.rdata) begin
            $display("%0t: rdata exp %h got %h", $time, e.rdata, got.rdata);
            errors++;
         end
         if (got.access_fault !== e.access_fault) begin
            $display("%0t: access_fault exp %b got %b", $time, e.access_fault,
                     got.access_fault);
            errors++;
         end
         if (got.irq_lines !== e.irq_lines) begin
            $display("%0t: irq_lines exp %b got %b", $time, e.irq_lines, got.irq_lines);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   plic_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   plic_rsp_type rsp_data;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [2:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   irq_ledger    ledger = new();
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           hold_asks = 0;
   int           hold_seen = 0;
   int           hold_left = 0;

   platform_interrupt_controller_unit u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_LONG;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) ledger.check_word(rsp_data);

   function automatic plic_req_type mk(logic [1:0] op, logic [23:0] a, logic [31:0] d,
                                       logic [4:0] sid);
      plic_req_type q;
      q.op = op;
      q.word_addr = a;
      q.wdata = d;
      q.source_id = sid;
      return q;
   endfunction

   function automatic logic [23:0] ctx_addr(int t, int r);
      return CTX_BASE + 24'(t * 1024 + r);
   endfunction

   function automatic plic_req_type random_word();
      plic_req_type q;
      int           k;
      logic [1:0]   rw;
      k = $urandom_range(99);
      rw = $urandom_range(1) ? OP_WRITE : OP_READ;
      q = mk(rw, '0, $urandom, 5'($urandom));
      if (k < 22) begin
         q.op = OP_RAISE;
      end else if (k < 32) begin
         q.op = OP_READ;
         q.word_addr = ctx_addr($urandom_range(4), CTX_CLAIM);
      end else if (k < 42) begin
         q.op = OP_WRITE;
         q.word_addr = ctx_addr($urandom_range(4), CTX_CLAIM);
         if ($urandom_range(7) != 0) q.wdata = $urandom_range(31);
      end else if (k < 54) begin
         q.op = OP_WRITE;
         q.word_addr = 24'($urandom_range(33));
      end else if (k < 62) begin
         q.op = OP_READ;
         q.word_addr = 24'($urandom_range(33));
      end else if (k < 70) begin
         q.word_addr = ENAB_BASE + 24'($urandom_range(4) * 32 +
                                       ($urandom_range(5) == 0 ? $urandom_range(31) : 0));
         q.wdata = $urandom | $urandom;
      end else if (k < 76) begin
         q.word_addr = ctx_addr($urandom_range(4), CTX_THRESHOLD);
         if ($urandom_range(1)) q.wdata = $urandom_range(3);
      end else if (k < 82) begin
         q.word_addr = PEND_BASE + 24'($urandom_range(3) == 0);
      end else if (k < 86) begin
         q.word_addr = ctx_addr($urandom_range(4), $urandom_range(1023, 2));
      end else if (k < 92) begin
         q.word_addr = 24'($urandom);
      end else if (k < 95) begin
         q.op = OP_NONE;
      end else begin
         q = plic_req_type'(63'({$urandom, $urandom}));
         q.word_addr = 24'($urandom);
         q.wdata = $urandom;
      end
      return q;
   endfunction

   // Offer one word and hold it until taken; starts and ends on a rising edge.
   task automatic send_word(plic_req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
      ledger.note_word(q);
   endtask

   task automatic csr_write(logic csr, logic [31:0] value);
      req_valid <= 1'b0;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {csr, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      ledger.set_cfg(csr, value);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.expected_rsps.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      int          srcs [6] = '{32, 1, 5, 32, 17, 32};
      int          tgts [6] = '{4, 1, 2, 1, 3, 4};
      plic_req_type directed [$];

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{
         mk(OP_WRITE, 24'd1, 32'hFFFF_FFFF, 5'd0), mk(OP_WRITE, 24'd2, 32'd5, 5'd31),
         mk(OP_WRITE, 24'd31, 32'd7, 5'd0), mk(OP_READ, 24'd1, 32'd0, 5'd0),
         mk(OP_READ, 24'd32, 32'd0, 5'd0),
         mk(OP_WRITE, ENAB_BASE, 32'hFFFF_FFFF, 5'd0),
         mk(OP_WRITE, ENAB_BASE + 24'd96, 32'h8000_0002, 5'd0),
         mk(OP_READ, ENAB_BASE + 24'd128, 32'd0, 5'd0),
         mk(OP_READ, ENAB_BASE + 24'd1, 32'd0, 5'd0),
         mk(OP_RAISE, 24'd0, 32'd0, 5'd0), mk(OP_RAISE, 24'd0, 32'd0, 5'd31),
         mk(OP_RAISE, 24'd0, 32'd0, 5'd1), mk(OP_RAISE, 24'd0, 32'd0, 5'd2),
         mk(OP_READ, PEND_BASE, 32'd0, 5'd0), mk(OP_WRITE, PEND_BASE, 32'hFFFF_FFFF, 5'd0),
         mk(OP_READ, PEND_BASE + 24'd1, 32'd0, 5'd0),
         mk(OP_WRITE, ctx_addr(0, CTX_THRESHOLD), 32'hFFFF_FFFE, 5'd0),
         mk(OP_READ, ctx_addr(0, CTX_THRESHOLD), 32'd0, 5'd0),
         mk(OP_READ, ctx_addr(0, CTX_CLAIM), 32'd0, 5'd0),
         mk(OP_WRITE, ctx_addr(0, CTX_CLAIM), 32'd1, 5'd0),
         mk(OP_WRITE, ctx_addr(0, CTX_CLAIM), 32'd0, 5'd0),
         mk(OP_READ, ctx_addr(3, CTX_CLAIM), 32'd0, 5'd0),
         mk(OP_READ, ctx_addr(0, 2), 32'd0, 5'd0),
         mk(OP_WRITE, ctx_addr(1, 1023), 32'hFFFF_FFFF, 5'd0),
         mk(OP_READ, ctx_addr(4, CTX_CLAIM), 32'd0, 5'd0),
         mk(OP_NONE, 24'hFFFFFF, 32'hFFFF_FFFF, 5'd31),
         mk(OP_READ, 24'hFFFFFF, 32'd0, 5'd0)
      };

      for (int p = 0; p < 6; p++) begin
         send_idle_pct = (p < 2) ? 27 : (p < 4) ? 87 : 0;
         recv_idle_pct = (p < 2) ? 87 : (p < 4) ? 27 : 0;
         if (p > 0) drain();
         csr_write(CSR_SOURCES, srcs[p]);
         csr_write(CSR_TARGETS, tgts[p]);
         if (p == 0)
            foreach (directed[i]) send_word(directed[i]);
         if (p == 4) hold_asks++;
         for (int n = 0; n < 330; n++) begin
            // saturate one source's tally once, then keep going at random
            if (p == 0 && n < 270) send_word(mk(OP_RAISE, 24'($urandom), $urandom, 5'd5));
            else send_word(random_word());
         end
      end
      drain();
      if (ledger.errors == 0 && ledger.expected_rsps.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #(64'd80_000_000);
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/plic_pkg.sv
rtl/core/plic_ram.sv
rtl/core/plic_core.sv
rtl/core/platform_interrupt_controller_unit.sv
dv/tb_top.sv
